@@ rtl/core/lsw_pkg.sv @@
// Shared types and constants for the level sweep threshold finder.
// No dependencies; every module of the block imports this package.
package lsw_pkg;

   localparam int MAX_POINTS = 64;
   localparam int PT_AW      = $clog2(MAX_POINTS);
   localparam int PT_CW      = PT_AW + 1;
   localparam int SUM_W      = 16 + PT_AW + 1;
   localparam int Y_W        = 18;
   localparam int DX_W       = 17;
   localparam int DEN_W      = 19;
   localparam int NUM_W      = 36;
   localparam int NUM_TGT    = 3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FEW  = 2'd1;
   localparam logic [1:0] STATUS_DROP = 2'd2;

   localparam logic [1:0] CSR_SMALL_LEVEL = 2'd0;
   localparam logic [1:0] CSR_THD_LOW     = 2'd1;
   localparam logic [1:0] CSR_THD_HIGH    = 2'd2;
   localparam logic [1:0] CSR_COMPRESSION = 2'd3;

   typedef struct packed {
      logic signed [15:0] level_q8;
      logic signed [15:0] gain_q8;
      logic [14:0]        thd_q8;
      logic               clip_seen;
      logic               last;
   } item_type;

   typedef struct packed {
      logic signed [15:0] level_q8;
      logic signed [15:0] gain_q8;
      logic [14:0]        thd_q8;
      logic               clip_seen;
   } point_type;

   typedef struct packed {
      logic signed [15:0] small_signal_level_q8;
      logic [14:0]        thd_low_q8;
      logic [14:0]        thd_high_q8;
      logic [14:0]        compression_q8;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               hard_clip_any;
      logic signed [15:0] small_gain_q8;
      logic               thd_low_valid;
      logic signed [15:0] thd_low_level_q8;
      logic               thd_high_valid;
      logic signed [15:0] thd_high_level_q8;
      logic               comp_valid;
      logic signed [15:0] comp_level_q8;
   } result_type;

endpackage

@@ rtl/core/level_sweep_threshold_finder_unit.sv @@
// Top level of the level sweep threshold finder: register port, front queue and back end.
// Depends on lsw_pkg, lsw_front and lsw_back.
//
// A point that is not last goes through the sorted insert in the back end, which moves
// every stored point with a higher level up one slot (one store read and one store
// write per moved point). A last point adds the averaging, the average division, the
// crossing scan and up to three interpolation divisions; averaging and interpolation
// share the one-bit-per-cycle divider, and both scans read the store through its
// single read port. The two-word input queue takes points while the back end is
// busy, and the result register lets the next sweep load while a result waits to be
// taken.
module level_sweep_threshold_finder_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_level_q8,
   input  logic signed [15:0] req_gain_q8,
   input  logic [14:0]        req_thd_q8,
   input  logic               req_clip_seen,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic               rsp_hard_clip_any,
   output logic signed [15:0] rsp_small_gain_q8,
   output logic               rsp_thd_low_valid,
   output logic signed [15:0] rsp_thd_low_level_q8,
   output logic               rsp_thd_high_valid,
   output logic signed [15:0] rsp_thd_high_level_q8,
   output logic               rsp_comp_valid,
   output logic signed [15:0] rsp_comp_level_q8,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import lsw_pkg::*;

   cfg_type    cfg_ff;
   item_type   req_item;
   item_type   q_item;
   logic       q_valid;
   logic       q_ready;
   result_type rsp_word;
   logic [1:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.small_signal_level_q8 <= -16'sd5120;
         cfg_ff.thd_low_q8            <= 15'd256;
         cfg_ff.thd_high_q8           <= 15'd768;
         cfg_ff.compression_q8        <= 15'd256;
      end else if (psel && penable && pwrite && pready) begin
         case (csr_idx)
            CSR_SMALL_LEVEL: cfg_ff.small_signal_level_q8 <= pwdata[15:0];
            CSR_THD_LOW:     cfg_ff.thd_low_q8            <= pwdata[14:0];
            CSR_THD_HIGH:    cfg_ff.thd_high_q8           <= pwdata[14:0];
            CSR_COMPRESSION: cfg_ff.compression_q8        <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_SMALL_LEVEL: prdata = {{16{cfg_ff.small_signal_level_q8[15]}},
                                    cfg_ff.small_signal_level_q8};
         CSR_THD_LOW:     prdata = {17'd0, cfg_ff.thd_low_q8};
         CSR_THD_HIGH:    prdata = {17'd0, cfg_ff.thd_high_q8};
         CSR_COMPRESSION: prdata = {17'd0, cfg_ff.compression_q8};
         default:         prdata = '0;
      endcase
   end

   assign req_item = '{req_level_q8, req_gain_q8, req_thd_q8, req_clip_seen, req_last};

   lsw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .in_stall  (req_stall),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_ready (q_ready)
   );

   lsw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (q_valid),
      .in_item   (q_item),
      .in_ready  (q_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

   assign rsp_status            = rsp_word.status;
   assign rsp_hard_clip_any     = rsp_word.hard_clip_any;
   assign rsp_small_gain_q8     = rsp_word.small_gain_q8;
   assign rsp_thd_low_valid     = rsp_word.thd_low_valid;
   assign rsp_thd_low_level_q8  = rsp_word.thd_low_level_q8;
   assign rsp_thd_high_valid    = rsp_word.thd_high_valid;
   assign rsp_thd_high_level_q8 = rsp_word.thd_high_level_q8;
   assign rsp_comp_valid        = rsp_word.comp_valid;
   assign rsp_comp_level_q8     = rsp_word.comp_level_q8;

endmodule

@@ rtl/core/lsw_front.sv @@
// Input side: a two-word queue that takes sweep points and hands them to the back end.
// Depends on lsw_pkg.
module lsw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lsw_pkg::item_type in_item,
   output logic              in_stall,
   output logic              out_valid,
   output lsw_pkg::item_type out_item,
   input  logic              out_ready
);
   import lsw_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       push;
   logic       pop;

   assign in_stall  = (fill_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (fill_ff != 2'd0);
   assign pop       = out_valid && out_ready;
   assign out_item  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= in_item;
   end

endmodule

@@ rtl/core/lsw_div.sv @@
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on lsw_pkg; shared by the averaging and interpolation steps.
module lsw_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [lsw_pkg::NUM_W-1:0] num,
   input  logic signed [lsw_pkg::DEN_W-1:0] den,
   output logic                             done,
   output logic signed [lsw_pkg::NUM_W-1:0] quo
);
   import lsw_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] dmag_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, dmag_ff});
   assign done  = done_ff;
   assign quo   = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         quo_ff  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         dmag_ff <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
         neg_ff  <= num[NUM_W-1] ^ den[DEN_W-1];
         rem_ff  <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= DEN_W'(trial - {1'b0, dmag_ff});
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= DEN_W'(trial);
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

endmodule

@@ rtl/core/lsw_back.sv @@
// Back end: sorted point store, small-signal averaging, crossing search and result register.
// Depends on lsw_pkg and lsw_div.
module lsw_back (
   input  logic                clock,
   input  logic                reset,
   input  lsw_pkg::cfg_type    cfg,
   input  logic                in_valid,
   input  lsw_pkg::item_type   in_item,
   output logic                in_ready,
   output logic                rsp_valid,
   output lsw_pkg::result_type rsp_word,
   input  logic                rsp_stall
);
   import lsw_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_INS_CHK, S_INS_CMP, S_INS_PUT, S_LAST,
      S_AVG_RD, S_AVG_ACC, S_AVG_GO, S_AVG_WAIT,
      S_SC_RD, S_SC_EVAL,
      S_RS_CHK, S_RS_MUL, S_RS_GO, S_RS_WAIT, S_RS_NEXT,
      S_EMIT
   } state_type;

   state_type          state_ff;
   point_type          mem [MAX_POINTS];
   point_type          rd_ff;
   point_type          pt_ff;
   point_type          prev_ff;
   logic               last_ff;
   logic [PT_CW-1:0]   count_ff;
   logic [PT_CW-1:0]   pos_ff;
   logic [PT_CW-1:0]   idx_ff;
   logic [PT_CW-1:0]   cnt_ff;
   logic               ovf_ff;
   logic               clip_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [15:0] g0_ff;

   logic [NUM_TGT-1:0]       found_ff;
   logic signed [15:0]       x0_ff  [NUM_TGT];
   logic signed [Y_W-1:0]    y0_ff  [NUM_TGT];
   logic signed [DX_W-1:0]   dx_ff  [NUM_TGT];
   logic signed [DEN_W-1:0]  dd_ff  [NUM_TGT];
   logic signed [15:0]       lvl_ff [NUM_TGT];
   logic [NUM_TGT-1:0]       lv_ff;
   logic [1:0]               k_ff;
   logic signed [NUM_W-1:0]  prod_ff;
   result_type               res_ff;
   result_type               rsp_ff;
   logic                     rsp_valid_ff;

   logic                     mem_we;
   logic [PT_AW-1:0]         mem_wa;
   point_type                mem_wd;
   logic                     mem_re;
   logic [PT_AW-1:0]         mem_ra;

   logic signed [Y_W-1:0]    tgt [NUM_TGT];
   logic signed [Y_W-1:0]    y0c [NUM_TGT];
   logic signed [Y_W-1:0]    y1c [NUM_TGT];
   logic [NUM_TGT-1:0]       brk;

   logic                     div_start;
   logic signed [NUM_W-1:0]  div_num;
   logic signed [DEN_W-1:0]  div_den;
   logic                     div_done;
   logic signed [NUM_W-1:0]  div_quo;
   logic signed [DEN_W-1:0]  neg_y0;

   assign in_ready  = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Store port control: insertion shifts one entry per read/compare pair.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = pos_ff[PT_AW-1:0];
      mem_wd = pt_ff;
      mem_re = 1'b0;
      mem_ra = idx_ff[PT_AW-1:0];
      case (state_ff)
         S_INS_CHK: begin
            mem_re = (pos_ff != '0);
            mem_ra = PT_AW'(pos_ff - 1'b1);
         end
         S_INS_CMP: begin
            mem_we = (rd_ff.level_q8 > pt_ff.level_q8);
            mem_wd = rd_ff;
         end
         S_INS_PUT: mem_we = 1'b1;
         S_AVG_RD, S_SC_RD: mem_re = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_ff <= mem[mem_ra];
   end

   // Offsets from the three targets on the segment from the previous to the current point.
   always_comb begin
      tgt[0] = Y_W'({3'b000, cfg.thd_low_q8});
      tgt[1] = Y_W'({3'b000, cfg.thd_high_q8});
      tgt[2] = $signed({{2{g0_ff[15]}}, g0_ff}) - $signed(Y_W'({3'b000, cfg.compression_q8}));
      for (int k = 0; k < NUM_TGT; k++) begin
         if (k == NUM_TGT - 1) begin
            y0c[k] = $signed({{2{prev_ff.gain_q8[15]}}, prev_ff.gain_q8}) - tgt[k];
            y1c[k] = $signed({{2{rd_ff.gain_q8[15]}}, rd_ff.gain_q8}) - tgt[k];
         end else begin
            y0c[k] = $signed({3'b000, prev_ff.thd_q8}) - tgt[k];
            y1c[k] = $signed({3'b000, rd_ff.thd_q8}) - tgt[k];
         end
         brk[k] = ((y0c[k] <= 0) && (y1c[k] >= 0)) || ((y0c[k] >= 0) && (y1c[k] <= 0));
      end
   end

   assign neg_y0 = -$signed({y0_ff[k_ff][Y_W-1], y0_ff[k_ff]});

   always_comb begin
      div_start = (state_ff == S_AVG_GO) || (state_ff == S_RS_GO);
      if (state_ff == S_AVG_GO) begin
         div_num = NUM_W'(sum_ff);
         div_den = DEN_W'({1'b0, cnt_ff});
      end else begin
         div_num = prod_ff;
         div_den = dd_ff[k_ff];
      end
   end

   lsw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  pt_ff   <= '{in_item.level_q8, in_item.gain_q8, in_item.thd_q8,
                               in_item.clip_seen};
                  last_ff <= in_item.last;
                  if (count_ff < PT_CW'(MAX_POINTS)) begin
                     pos_ff   <= count_ff;
                     state_ff <= S_INS_CHK;
                  end else begin
                     ovf_ff   <= 1'b1;
                     state_ff <= S_LAST;
                  end
               end
            end
            S_INS_CHK: state_ff <= (pos_ff == '0) ? S_INS_PUT : S_INS_CMP;
            S_INS_CMP: begin
               if (rd_ff.level_q8 > pt_ff.level_q8) begin
                  pos_ff   <= pos_ff - 1'b1;
                  state_ff <= S_INS_CHK;
               end else begin
                  state_ff <= S_INS_PUT;
               end
            end
            S_INS_PUT: begin
               count_ff <= count_ff + 1'b1;
               clip_ff  <= clip_ff | pt_ff.clip_seen;
               state_ff <= S_LAST;
            end
            S_LAST: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (count_ff < PT_CW'(2)) begin
                  res_ff   <= '{status: STATUS_FEW, default: '0};
                  state_ff <= S_EMIT;
               end else begin
                  idx_ff   <= '0;
                  sum_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_AVG_RD;
               end
            end
            S_AVG_RD: state_ff <= S_AVG_ACC;
            S_AVG_ACC: begin
               if (rd_ff.level_q8 <= cfg.small_signal_level_q8 || cnt_ff < PT_CW'(2)) begin
                  sum_ff <= sum_ff + SUM_W'(rd_ff.gain_q8);
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (idx_ff == count_ff - 1'b1) begin
                  state_ff <= S_AVG_GO;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_AVG_RD;
               end
            end
            S_AVG_GO: state_ff <= S_AVG_WAIT;
            S_AVG_WAIT: begin
               if (div_done) begin
                  g0_ff    <= div_quo[15:0];
                  idx_ff   <= '0;
                  found_ff <= '0;
                  state_ff <= S_SC_RD;
               end
            end
            S_SC_RD: state_ff <= S_SC_EVAL;
            S_SC_EVAL: begin
               prev_ff <= rd_ff;
               if (idx_ff != '0) begin
                  for (int k = 0; k < NUM_TGT; k++) begin
                     if (!found_ff[k] && brk[k]) begin
                        found_ff[k] <= 1'b1;
                        x0_ff[k]    <= prev_ff.level_q8;
                        y0_ff[k]    <= y0c[k];
                        dx_ff[k]    <= $signed({rd_ff.level_q8[15], rd_ff.level_q8})
                                       - $signed({prev_ff.level_q8[15], prev_ff.level_q8});
                        dd_ff[k]    <= $signed({y1c[k][Y_W-1], y1c[k]})
                                       - $signed({y0c[k][Y_W-1], y0c[k]});
                     end
                  end
               end
               if (idx_ff == count_ff - 1'b1) begin
                  k_ff     <= '0;
                  state_ff <= S_RS_CHK;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SC_RD;
               end
            end
            S_RS_CHK: begin
               if (!found_ff[k_ff]) begin
                  lv_ff[k_ff]  <= 1'b0;
                  lvl_ff[k_ff] <= '0;
                  state_ff     <= S_RS_NEXT;
               end else if (dd_ff[k_ff] == '0) begin
                  lv_ff[k_ff]  <= 1'b1;
                  lvl_ff[k_ff] <= x0_ff[k_ff];
                  state_ff     <= S_RS_NEXT;
               end else begin
                  state_ff <= S_RS_MUL;
               end
            end
            S_RS_MUL: begin
               prod_ff  <= neg_y0 * dx_ff[k_ff];
               state_ff <= S_RS_GO;
            end
            S_RS_GO: state_ff <= S_RS_WAIT;
            S_RS_WAIT: begin
               if (div_done) begin
                  lv_ff[k_ff]  <= 1'b1;
                  lvl_ff[k_ff] <= x0_ff[k_ff] + div_quo[15:0];
                  state_ff     <= S_RS_NEXT;
               end
            end
            S_RS_NEXT: begin
               if (k_ff == 2'(NUM_TGT - 1)) begin
                  res_ff.status            <= ovf_ff ? STATUS_DROP : STATUS_OK;
                  res_ff.hard_clip_any     <= clip_ff;
                  res_ff.small_gain_q8     <= g0_ff;
                  res_ff.thd_low_valid     <= lv_ff[0];
                  res_ff.thd_low_level_q8  <= lvl_ff[0];
                  res_ff.thd_high_valid    <= lv_ff[1];
                  res_ff.thd_high_level_q8 <= lvl_ff[1];
                  res_ff.comp_valid        <= lv_ff[2];
                  res_ff.comp_level_q8     <= lvl_ff[2];
                  state_ff                 <= S_EMIT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_RS_CHK;
               end
            end
            S_EMIT: begin
               // The output word may still be waiting; hold until it has been taken.
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  count_ff     <= '0;
                  ovf_ff       <= 1'b0;
                  clip_ff      <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/core/lsw_checker.sv @@
// Port-level checks for the level sweep threshold finder, bound to the top level.
// Depends on level_sweep_threshold_finder_unit and lsw_pkg.
module lsw_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic signed [15:0] rsp_small_gain_q8,
   input logic               rsp_thd_low_valid,
   input logic signed [15:0] rsp_thd_low_level_q8,
   input logic               rsp_comp_valid,
   input logic signed [15:0] rsp_comp_level_q8,
   input logic               pready
);
   import lsw_pkg::*;

   // A stalled result word keeps its status.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_FEW ||
                     rsp_status == STATUS_DROP))
      else $error("undefined status code");

   // A sweep with too few points reports nothing but its status.
   a_few_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FEW |->
         rsp_small_gain_q8 == 16'sd0 && !rsp_thd_low_valid && !rsp_comp_valid)
      else $error("insufficient-points word carries data");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_thd_low_valid && !rsp_comp_valid |->
         rsp_thd_low_level_q8 == 16'sd0 && rsp_comp_level_q8 == 16'sd0)
      else $error("crossing level set without a crossing");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port not ready");

endmodule

bind level_sweep_threshold_finder_unit lsw_checker u_lsw_checker (.*);

@@ test/level_sweep_threshold_finder_unit_tb.sv @@
// Testbench for the level sweep threshold finder: drives level-sweep points,
// predicts each sweep result in a behavioral model and compares field by field.
// Depends on lsw_pkg and level_sweep_threshold_finder_unit.
`timescale 1ns / 100ps

module level_sweep_threshold_finder_unit_tb;
   import lsw_pkg::*;

   localparam int SWEEP_CAP = 64;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_level_q8;
   logic signed [15:0] req_gain_q8;
   logic [14:0]        req_thd_q8;
   logic               req_clip_seen;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic               rsp_hard_clip_any;
   logic signed [15:0] rsp_small_gain_q8;
   logic               rsp_thd_low_valid;
   logic signed [15:0] rsp_thd_low_level_q8;
   logic               rsp_thd_high_valid;
   logic signed [15:0] rsp_thd_high_level_q8;
   logic               rsp_comp_valid;
   logic signed [15:0] rsp_comp_level_q8;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [3:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   level_sweep_threshold_finder_unit u_dut (.*);

   // Predictor state.
   point_type  sorted_pts[SWEEP_CAP];
   int         pt_count;
   bit         dropped;
   bit         clip_any;
   cfg_type    cfg;
   result_type sweep_results[$];

   int  mismatches;
   int  hold_cycles;
   bit  hold_now;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic signed [15:0] crossing_level(input bit use_gain,
                                                        input longint target,
                                                        output bit found);
      longint y0, y1, dx, term;
      found = 1'b0;
      for (int i = 1; i < pt_count; i++) begin
         y0 = (use_gain ? longint'(sorted_pts[i-1].gain_q8)
                        : longint'(sorted_pts[i-1].thd_q8)) - target;
         y1 = (use_gain ? longint'(sorted_pts[i].gain_q8)
                        : longint'(sorted_pts[i].thd_q8)) - target;
         if ((y0 <= 0 && y1 >= 0) || (y0 >= 0 && y1 <= 0)) begin
            found = 1'b1;
            if (y1 == y0) return sorted_pts[i-1].level_q8;
            dx = longint'(sorted_pts[i].level_q8) - longint'(sorted_pts[i-1].level_q8);
            term = (-y0 * dx) / (y1 - y0);
            return 16'(longint'(sorted_pts[i-1].level_q8) + term);
         end
      end
      return '0;
   endfunction

   // Inserts one point and, on the last point, predicts the sweep result.
   task automatic predict_point(input item_type it);
      int         pos, cnt;
      longint     sum, g0;
      result_type r;
      bit         f;
      if (pt_count < SWEEP_CAP) begin
         pos = pt_count;
         while (pos > 0 && sorted_pts[pos-1].level_q8 > it.level_q8) begin
            sorted_pts[pos] = sorted_pts[pos-1];
            pos--;
         end
         sorted_pts[pos] = '{it.level_q8, it.gain_q8, it.thd_q8, it.clip_seen};
         pt_count++;
         if (it.clip_seen) clip_any = 1'b1;
      end else begin
         dropped = 1'b1;
      end
      if (!it.last) return;
      r = '0;
      if (pt_count < 2) begin
         r.status = STATUS_FEW;
      end else begin
         sum = 0;
         cnt = 0;
         for (int i = 0; i < pt_count; i++)
            if (sorted_pts[i].level_q8 <= cfg.small_signal_level_q8 || cnt < 2) begin
               sum += sorted_pts[i].gain_q8;
               cnt++;
            end
         g0 = sum / cnt;
         r.status = dropped ? STATUS_DROP : STATUS_OK;
         r.hard_clip_any = clip_any;
         r.small_gain_q8 = 16'(g0);
         r.thd_low_level_q8 = crossing_level(1'b0, longint'(cfg.thd_low_q8), f);
         r.thd_low_valid = f;
         r.thd_high_level_q8 = crossing_level(1'b0, longint'(cfg.thd_high_q8), f);
         r.thd_high_valid = f;
         r.comp_level_q8 = crossing_level(1'b1, g0 - longint'(cfg.compression_q8), f);
         r.comp_valid = f;
      end
      sweep_results = {sweep_results, r};
      pt_count = 0;
      dropped = 1'b0;
      clip_any = 1'b0;
   endtask

   // Idle gap before a word; the input is taken low only when a gap is inserted.
   task automatic random_gap(input int pct);
      int n;
      if ($urandom_range(99) >= pct) return;
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Sends one word and updates the prediction when it is accepted.
   task automatic send_point(input item_type it, input int gap_pct = 30);
      random_gap(gap_pct);
      req_valid     <= 1'b1;
      req_level_q8  <= it.level_q8;
      req_gain_q8   <= it.gain_q8;
      req_thd_q8    <= it.thd_q8;
      req_clip_seen <= it.clip_seen;
      req_last      <= it.last;
      do @(posedge clock); while (req_stall);
      predict_point(it);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         CSR_SMALL_LEVEL: cfg.small_signal_level_q8 = value[15:0];
         CSR_THD_LOW:     cfg.thd_low_q8 = value[14:0];
         CSR_THD_HIGH:    cfg.thd_high_q8 = value[14:0];
         default:         cfg.compression_q8 = value[14:0];
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sweep_results.size() != 0) @(negedge clock);
      // Up to three points left without a last word may still be inserting.
      repeat (450) @(negedge clock);
   endtask

   function automatic item_type rand_point(input bit is_last);
      item_type it;
      it.level_q8  = 16'($urandom);
      it.gain_q8   = 16'($urandom);
      it.thd_q8    = 15'($urandom);
      it.clip_seen = ($urandom_range(7) == 0);
      it.last      = is_last;
      return it;
   endfunction

   // A plausible sweep: rising level, gain flat then compressing, THD rising.
   task automatic send_sweep(input int n, input int gap_pct);
      item_type it;
      int base, lvl;
      base = $urandom_range(2000, 0);
      for (int i = 0; i < n; i++) begin
         lvl = -12000 + $urandom_range(600, 0) * i / 2 - 200 + $urandom_range(400);
         it.level_q8  = 16'(lvl);
         it.gain_q8   = 16'(base - ((i > n / 2) ? (i - n / 2) * $urandom_range(200) : 0)
                            + $urandom_range(40) - 20);
         it.thd_q8    = 15'(i * $urandom_range(120) + $urandom_range(30));
         it.clip_seen = (i == n - 1) && $urandom_range(1);
         it.last      = (i == n - 1);
         if ($urandom_range(19) == 0) it = rand_point(it.last);
         send_point(it, gap_pct);
      end
   endtask

   task automatic test_directed();
      item_type it;
      // A single last point (too few points), then a four-point sweep at the level extremes.
      it = '{16'sd0, 16'sd100, 15'd0, 1'b1, 1'b1};
      send_point(it);
      it = '{16'sh7fff, 16'sh7fff, 15'h7fff, 1'b0, 1'b0};
      send_point(it);
      it = '{16'sh8000, 16'sh8000, 15'd0, 1'b1, 1'b0};
      send_point(it);
      it = '{16'sh8000, 16'sd0, 15'd300, 1'b0, 1'b0};
      send_point(it);
      it = '{16'sh7fff, 16'sd5, 15'd900, 1'b0, 1'b1};
      send_point(it);
      // Equal levels keep arrival order; flat THD equal to threshold.
      for (int i = 0; i < 4; i++) begin
         it = '{16'sd10, 16'(i * 50), 15'd256, 1'b0, i == 3};
         send_point(it);
      end
      // No crossing at all.
      it = '{-16'sd100, 16'sd0, 15'd0, 1'b0, 1'b0};
      send_point(it);
      it = '{16'sd100, 16'sd0, 15'd0, 1'b0, 1'b1};
      send_point(it);
      wait_drained();
   endtask

   task automatic test_overflow();
      for (int i = 0; i < SWEEP_CAP + 3; i++)
         send_point(rand_point(i == SWEEP_CAP + 2), 5);
      wait_drained();
   endtask

   task automatic test_config_corners();
      csr_write(CSR_SMALL_LEVEL, 32'h0000_7fff);
      csr_write(CSR_THD_LOW, 32'h0000_0000);
      csr_write(CSR_THD_HIGH, 32'h0000_7fff);
      csr_write(CSR_COMPRESSION, 32'h0000_7fff);
      repeat (4) send_sweep($urandom_range(8, 2), 30);
      wait_drained();
      csr_write(CSR_SMALL_LEVEL, 32'h0000_8000);
      csr_write(CSR_THD_LOW, 32'h0000_7fff);
      csr_write(CSR_THD_HIGH, 32'h0000_0000);
      csr_write(CSR_COMPRESSION, 32'h0000_0000);
      repeat (4) send_sweep($urandom_range(8, 2), 30);
      wait_drained();
   endtask

   task automatic test_backpressure();
      // Receiver holds off while a burst of sweeps is offered.
      hold_cycles = 600;
      repeat (6) send_sweep($urandom_range(6, 2), 0);
      wait_drained();
   endtask

   task automatic test_random();
      int sent;
      sent = 0;
      while (sent < 300) begin
         if ($urandom_range(9) == 0) begin
            wait_drained();
            csr_write(2'($urandom_range(3)), $urandom);
         end
         if ($urandom_range(7) == 0) begin
            send_point(rand_point($urandom_range(2) == 0));
            sent++;
         end else begin
            int n;
            n = ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(9, 2);
            send_sweep(n, ($urandom_range(3) == 0) ? 0 : 30);
            sent += n;
         end
      end
      send_point(rand_point(1'b1));
   endtask

   // Receiver stall: random, or held for a counted stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1'b1;
      end else if (hold_now) begin
         rsp_stall <= ($urandom_range(3) == 0);
         if ($urandom_range(49) == 0) hold_now <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(49) == 0) hold_now <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_hard_clip_any, rsp_small_gain_q8, rsp_thd_low_valid,
                 rsp_thd_low_level_q8, rsp_thd_high_valid, rsp_thd_high_level_q8,
                 rsp_comp_valid, rsp_comp_level_q8};
         if (sweep_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
         end else begin
            want = sweep_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      hold_cycles = 0;
      hold_now = 1'b0;
      pt_count = 0;
      dropped = 1'b0;
      clip_any = 1'b0;
      cfg = '{-16'sd5120, 15'd256, 15'd768, 15'd256};
      reset = 1'b1;
      req_valid = 1'b0;
      req_level_q8 = '0;
      req_gain_q8 = '0;
      req_thd_q8 = '0;
      req_clip_seen = 1'b0;
      req_last = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_overflow();
      test_config_corners();
      test_backpressure();
      test_random();
      wait_drained();
      if (mismatches == 0 && sweep_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
